/* rtl/rlbc_pkg.sv */
// package for the resonant lowpass biquad cascade: widths, fixed-point formats,
// register indexes and the control structs shared by the top level and the multiplier
// no dependencies
`default_nettype none

package rlbc_pkg;

  localparam int SECTIONS    = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_BITS  = 40;

  localparam int GAIN_BITS  = 47;
  localparam int COEF_BITS  = 32;
  localparam int GAIN_FRAC  = 46;
  localparam int COEF_FRAC  = 30;
  localparam int GUARD_BITS = 8;
  localparam int WORK_FRAC  = SAMPLE_BITS - 1 + GUARD_BITS;
  localparam int GAIN_SHIFT = GAIN_FRAC + SAMPLE_BITS - 1 - WORK_FRAC;

  // multiplier operand and product widths
  localparam int MPL_W = GAIN_BITS + 1;
  localparam int MUL_W = DELAY_BITS + MPL_W;
  localparam int CNT_W = $clog2(MPL_W);

  // three-term sums of delay-width words
  localparam int SUM_W = DELAY_BITS + 2;

  // coefficient sets held in registers, section index width
  localparam int COEF_SETS = 2;
  localparam int SEC_W     = 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_POLE_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_POLE_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_POLE_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_POLE_B = 3'd4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [DELAY_BITS-1:0]  delay_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  localparam delay_t DELAY_MAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
  localparam delay_t DELAY_MIN = {1'b1, {(DELAY_BITS-1){1'b0}}};

  typedef struct packed {
    logic start;
    logic coef_mode;
  } mul_ctrl_t;

  typedef struct packed {
    logic   done;
    delay_t prod;
  } mul_stat_t;

endpackage

`default_nettype wire

/* rtl/rlbc_in_if.sv */
// input channel of the biquad cascade: valid, ready and one audio sample
// depends on rlbc_pkg
`default_nettype none

interface rlbc_in_if;
  import rlbc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

/* rtl/rlbc_out_if.sv */
// output channel of the biquad cascade: valid, ready and one filtered sample
// depends on rlbc_pkg
`default_nettype none

interface rlbc_out_if;
  import rlbc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* rtl/resonant_lowpass_biquad_cascade_top.sv */
// 24 dB/octave resonant lowpass: input gain and two direct-form-II biquads in series,
// all products on one bit-serial multiplier; depends on rlbc_pkg, rlbc_in_if,
// rlbc_out_if and rlbc_ser_mul
//
// usage:
//   in_i carries one signed audio sample per item, out_o one filtered sample per item.
//   the registers (input gain, two pole coefficients per section) are written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while no item is in flight; unknown indexes are
//   ignored. all registers reset to zero, so the output is zero until the gain is set.
//   every product goes through the one multiplier, one multiplier bit per clock:
//   48 steps for the gain, 32 for each coefficient, then the product is shifted,
//   saturated to a delay word and handed over.
//   an accepted item goes through the gain product, then per section a setup step,
//   the two coefficient products and the delay update, then the emit step; no new
//   item is taken until the previous one has been emitted.
//   the result sits in an output register; the next item is accepted and worked on
//   while it waits, and only the emit step stalls until out_o.ready frees it.
//   reset clears the delay words, the registers and all handshake state.
`default_nettype none

module resonant_lowpass_biquad_cascade_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  rlbc_in_if.sink                        in_i,
  rlbc_out_if.source                     out_o,
  input  wire                            cfg_we_i,
  input  wire [rlbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [rlbc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rlbc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WAIT_G = 3'd1;
  localparam logic [2:0] ST_START  = 3'd2;
  localparam logic [2:0] ST_WAIT_A = 3'd3;
  localparam logic [2:0] ST_WAIT_B = 3'd4;
  localparam logic [2:0] ST_UPD    = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [SEC_W-1:0]     sec_q, sec_d;
  logic [GAIN_BITS-1:0] gain_q;
  coef_t                pole_a_q [COEF_SETS];
  coef_t                pole_b_q [COEF_SETS];
  delay_t               d_q [2*SECTIONS];
  delay_t               d_d [2*SECTIONS];
  delay_t               s_q, s_d, p1_q, p1_d, w_q, w_d;
  logic                 out_valid_q, out_valid_d;
  sample_t              out_data_q;
  logic                 emit;

  mul_ctrl_t            mul_ctrl;
  mul_stat_t            mul_stat;
  delay_t               mcand;
  logic [MPL_W-1:0]     mplier;

  function automatic delay_t sat_sum(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DELAY_BITS:0] hi;
    hi = v[SUM_W-1:DELAY_BITS-1];
    if (&hi || ~|hi) begin
      return v[DELAY_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      return DELAY_MIN;
    end else begin
      return DELAY_MAX;
    end
  endfunction

  // drop the guard bits and clamp to the sample range
  function automatic sample_t sat_out(input delay_t v);
    logic [DELAY_BITS-GUARD_BITS-SAMPLE_BITS:0] hi;
    hi = v[DELAY_BITS-1:GUARD_BITS+SAMPLE_BITS-1];
    if (&hi || ~|hi) begin
      return v[GUARD_BITS+SAMPLE_BITS-1:GUARD_BITS];
    end else if (v[DELAY_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  rlbc_ser_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mul_ctrl),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .stat_o   (mul_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
      for (int i = 0; i < COEF_SETS; i++) begin
        pole_a_q[i] <= '0;
        pole_b_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INPUT_GAIN:    gain_q      <= cfg_data_i[GAIN_BITS-1:0];
        REG_FIRST_POLE_A:  pole_a_q[0] <= cfg_data_i[COEF_BITS-1:0];
        REG_FIRST_POLE_B:  pole_b_q[0] <= cfg_data_i[COEF_BITS-1:0];
        REG_SECOND_POLE_A: pole_a_q[1] <= cfg_data_i[COEF_BITS-1:0];
        REG_SECOND_POLE_B: pole_b_q[1] <= cfg_data_i[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d            = state_q;
    sec_d              = sec_q;
    s_d                = s_q;
    p1_d               = p1_q;
    w_d                = w_q;
    d_d                = d_q;
    emit               = 1'b0;
    mul_ctrl.start     = 1'b0;
    mul_ctrl.coef_mode = 1'b1;
    mcand              = d_q[0];
    mplier             = MPL_W'(pole_a_q[sec_q]);
    unique case (state_q)
      ST_IDLE: begin
        mcand              = DELAY_BITS'(in_i.sample_in);
        mplier             = {1'b0, gain_q};
        mul_ctrl.coef_mode = 1'b0;
        if (in_i.valid) begin
          mul_ctrl.start = 1'b1;
          sec_d          = '0;
          state_d        = ST_WAIT_G;
        end
      end
      ST_WAIT_G: begin
        if (mul_stat.done) begin
          s_d     = mul_stat.prod;
          state_d = ST_START;
        end
      end
      ST_START: begin
        mul_ctrl.start = 1'b1;
        state_d        = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        mcand  = d_q[1];
        mplier = MPL_W'(pole_b_q[sec_q]);
        if (mul_stat.done) begin
          p1_d           = mul_stat.prod;
          mul_ctrl.start = 1'b1;
          state_d        = ST_WAIT_B;
        end
      end
      ST_WAIT_B: begin
        if (mul_stat.done) begin
          w_d     = sat_sum(SUM_W'(s_q) - SUM_W'(p1_q) - SUM_W'(mul_stat.prod));
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        s_d = sat_sum(SUM_W'(w_q) + (SUM_W'(d_q[0]) <<< 1) + SUM_W'(d_q[1]));
        // rotate so the next section's delay pair sits at the front
        for (int k = 0; k < 2*SECTIONS-2; k++) begin
          d_d[k] = d_q[k+2];
        end
        d_d[2*SECTIONS-2] = w_q;
        d_d[2*SECTIONS-1] = d_q[0];
        if (sec_q == SEC_W'(SECTIONS - 1)) begin
          state_d = ST_EMIT;
        end else begin
          sec_d   = SEC_W'(sec_q + 1'b1);
          state_d = ST_START;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = emit | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 2*SECTIONS; k++) begin
        d_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
      d_q         <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q  <= s_d;
    p1_q <= p1_d;
    w_q  <= w_d;
    if (emit) begin
      out_data_q <= sat_out(s_q);
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> (state_q == ST_WAIT_G || state_q == ST_WAIT_A ||
                       state_q == ST_WAIT_B))
    else $error("multiplier finished outside a wait state");

  a_accept_starts_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_WAIT_G))
    else $error("accepted item did not start the gain product");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_valid_q && !out_o.ready) |=>
      (state_q == ST_EMIT && out_valid_q))
    else $error("result lost while output register was full");

  a_last_section_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && sec_q == SEC_W'(SECTIONS - 1)) |=> (state_q == ST_EMIT))
    else $error("last section did not lead to emit");

endmodule

`default_nettype wire

/* rtl/rlbc_ser_mul.sv */
// bit-serial signed multiplier: one multiplier bit per cycle, then shift and saturate
// to a delay word; depends on rlbc_pkg
`default_nettype none

module rlbc_ser_mul (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire rlbc_pkg::mul_ctrl_t   ctrl_i,
  input  wire rlbc_pkg::delay_t      mcand_i,
  input  wire [rlbc_pkg::MPL_W-1:0]  mplier_i,
  output rlbc_pkg::mul_stat_t        stat_o
);
  import rlbc_pkg::*;

  logic               busy_q, busy_d;
  logic               fin_q, fin_d;
  logic               done_q;
  logic               mode_q, mode_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic signed [MUL_W-1:0] a_q, acc_q, acc_nxt, shifted;
  logic [MPL_W-1:0]        b_q;
  delay_t                  prod_q;

  function automatic delay_t sat_prod(input logic signed [MUL_W-1:0] v);
    logic [MUL_W-DELAY_BITS:0] hi;
    hi = v[MUL_W-1:DELAY_BITS-1];
    if (&hi || ~|hi) begin
      return v[DELAY_BITS-1:0];
    end else if (v[MUL_W-1]) begin
      return DELAY_MIN;
    end else begin
      return DELAY_MAX;
    end
  endfunction

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      mode_d = ctrl_i.coef_mode;
      cnt_d  = ctrl_i.coef_mode ? CNT_W'(COEF_BITS - 1) : CNT_W'(MPL_W - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  // the top multiplier bit carries negative weight
  always_comb begin
    acc_nxt = acc_q;
    if (b_q[0]) begin
      acc_nxt = (cnt_q == '0) ? (acc_q - a_q) : (acc_q + a_q);
    end
  end

  assign shifted = mode_q ? (acc_q >>> COEF_FRAC) : (acc_q >>> GAIN_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= fin_q;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q   <= MUL_W'(mcand_i);
      b_q   <= mplier_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_nxt;
      a_q   <= a_q <<< 1;
      b_q   <= b_q >> 1;
    end
    if (fin_q) begin
      prod_q <= sat_prod(shifted);
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.prod = prod_q;

endmodule

`default_nettype wire
